FILE: hw/rtl/ctlp_pkg.sv
package ctlp_pkg;

    // Data bytes carried by one CAN frame result.
    localparam int FRAME_BYTE_SLOTS = 8;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Value returned by the digit decoder for a character that is not hex.
    localparam logic [4:0] HEX_NONE = 5'd16;

    // Where the parser stands within the current line.
    typedef enum logic [1:0] {
        PH_START,
        PH_TOKEN,
        PH_GAP,
        PH_GAP_FIRST
    } t_phase;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_FRAME = 2'd0,
        ST_SKIP  = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    // Decodes one ASCII hex digit; any other character gives HEX_NONE.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = HEX_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h37);
        end
        return d;
    endfunction

endpackage

FILE: hw/rtl/can_text_line_parser.sv
// ASCII CAN frame line parser.
// Input channel (i_in_valid / o_in_ready): one request per character of a text
// line, with i_no_char marking a request without a character and
// i_end_of_line marking the last request of the line. Each accepted character
// updates the line state in the same cycle.
// Output channel (o_out_valid / i_out_ready): one request per line, holding the
// status (frame, skip or malformed), the identifier, the length and eight data
// bytes. The result shows in the cycle after the end-of-line request is accepted.
// Throughput is one character per cycle, set by the single registered update of
// the line state; the output register lets a new character be accepted in the
// same cycle as the waiting result is taken.
// When the receiver stalls with a result held, o_in_ready drops until that
// result is taken, so no request is lost.
// Reset returns the parser to the start of a line and empties the output
// register; the data byte store needs no clearing because only bytes written
// during the current line are ever shown.
module can_text_line_parser
    import ctlp_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8,
    parameter int ID_BITS        = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_no_char,
    input  logic        i_end_of_line,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_frame_id,
    output logic [3:0]  o_length,
    output logic [7:0]  o_byte0,
    output logic [7:0]  o_byte1,
    output logic [7:0]  o_byte2,
    output logic [7:0]  o_byte3,
    output logic [7:0]  o_byte4,
    output logic [7:0]  o_byte5,
    output logic [7:0]  o_byte6,
    output logic [7:0]  o_byte7
);

    // Token counter saturates at MAX_DATA_BYTES + 2.
    localparam int TCW = $clog2(MAX_DATA_BYTES + 3);
    localparam logic [TCW-1:0] TC_CAP  = TCW'(MAX_DATA_BYTES + 2);
    localparam logic [TCW-1:0] TC_OVER = TCW'(MAX_DATA_BYTES + 1);
    localparam logic [TCW-1:0] TC_ONE  = TCW'(1);
    localparam logic [TCW-1:0] TC_TWO  = TCW'(2);

    // Line state.
    t_phase               r_phase, n_phase;
    logic [TCW-1:0]       r_tc, n_tc;
    logic [ID_BITS-1:0]   r_id, n_id;
    logic                 r_ovf, n_ovf;
    logic [8:0]           r_ba, n_ba;
    logic                 r_pend, n_pend;
    logic                 r_skip, n_skip;
    logic                 r_bad, n_bad;
    logic [7:0]           r_store [FRAME_BYTE_SLOTS];

    // Output register.
    logic                 r_out_valid;
    t_status              r_out_status, n_out_status;
    logic [31:0]          r_out_id, n_out_id;
    logic [3:0]           r_out_len, n_out_len;
    logic [7:0]           r_out_byte [FRAME_BYTE_SLOTS];
    logic [7:0]           n_out_byte [FRAME_BYTE_SLOTS];

    logic                 in_acc;
    logic                 take;
    logic                 eol_acc;
    logic                 is_blank;
    logic                 is_brk;
    logic                 is_tok;
    t_phase               ph_char;
    logic                 wr_en;
    logic [2:0]           wr_idx;
    logic [7:0]           wr_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign take       = in_acc && !i_no_char;
    assign eol_acc    = in_acc && i_end_of_line;

    // Character classes.
    assign is_blank = (i_ch == CH_SPACE) || (i_ch == CH_TAB);
    assign is_brk   = (i_ch == CH_CR) || (i_ch == CH_LF);
    assign is_tok   = !is_blank && !is_brk;

    // Next phase: character effect first, then the line end returns to start.
    always_comb begin
        ph_char = r_phase;
        if (take) begin
            if (is_blank) begin
                if (r_phase == PH_TOKEN) begin
                    ph_char = PH_GAP;
                end
            end else if (is_brk) begin
                if (r_phase == PH_TOKEN) begin
                    ph_char = (r_tc == TC_ONE) ? PH_GAP_FIRST : PH_GAP;
                end else if (r_phase == PH_START) begin
                    ph_char = PH_GAP_FIRST;
                end
            end else begin
                ph_char = PH_TOKEN;
            end
        end
        n_phase = eol_acc ? PH_START : ph_char;
    end

    // Token, identifier and byte accumulation, then the line result.
    always_comb begin
        logic [4:0]     d;
        logic           close;
        logic [TCW-1:0] idx;
        logic [7:0]     len8;
        logic           tc_zero;

        n_tc    = r_tc;
        n_id    = r_id;
        n_ovf   = r_ovf;
        n_ba    = r_ba;
        n_pend  = r_pend;
        n_skip  = r_skip;
        n_bad   = r_bad;
        close   = 1'b0;
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = '0;
        d       = hex_digit(i_ch);

        if (take) begin
            if (is_blank || is_brk) begin
                close  = (r_phase == PH_TOKEN);
                n_pend = n_pend || is_brk;
            end else begin
                // A held-back line break now sits inside a token.
                if (r_pend) begin
                    if (r_phase == PH_GAP_FIRST) begin
                        n_skip = 1'b1;
                    end else begin
                        n_bad = 1'b1;
                    end
                    n_pend = 1'b0;
                end
                // Opening a new token.
                if (r_phase != PH_TOKEN) begin
                    if (r_tc < TC_CAP) begin
                        n_tc = r_tc + TC_ONE;
                    end
                    if (n_tc > TC_OVER) begin
                        n_bad = 1'b1;
                    end
                    n_ba = '0;
                end
                // Digit goes to the identifier or to the current data byte.
                if (n_tc == TC_ONE) begin
                    if (d == HEX_NONE) begin
                        n_skip = 1'b1;
                    end else begin
                        if (r_id[ID_BITS-1 -: 4] != 4'd0) begin
                            n_ovf = 1'b1;
                        end
                        n_id = {r_id[ID_BITS-5:0], d[3:0]};
                    end
                end else begin
                    if (d == HEX_NONE) begin
                        n_bad = 1'b1;
                    end else if (n_ba[8:4] != 5'd0) begin
                        n_ba = 9'd256;
                    end else begin
                        n_ba = {1'b0, n_ba[3:0], d[3:0]};
                    end
                end
            end
        end

        // The line end closes a token still open.
        if (eol_acc && ph_char == PH_TOKEN) begin
            close = 1'b1;
        end

        // Closing a data token checks its range and stores the byte.
        idx = n_tc - TC_TWO;
        if (close && n_tc >= TC_TWO) begin
            if (n_ba[8]) begin
                n_bad = 1'b1;
            end
            if (32'(idx) < MAX_DATA_BYTES && 32'(idx) < FRAME_BYTE_SLOTS) begin
                wr_en   = 1'b1;
                wr_idx  = 3'(idx);
                wr_data = n_ba[7:0];
            end
        end

        // Line result.
        tc_zero = (n_tc == '0);
        len8    = 8'(n_tc) - 8'd1;
        if (tc_zero || n_skip) begin
            n_out_status = ST_SKIP;
        end else if (n_bad || n_ovf) begin
            n_out_status = ST_BAD;
        end else begin
            n_out_status = ST_FRAME;
        end
        n_out_id  = '0;
        n_out_len = '0;
        for (int k = 0; k < FRAME_BYTE_SLOTS; k++) begin
            n_out_byte[k] = '0;
        end
        if (n_out_status == ST_FRAME) begin
            n_out_id  = 32'(n_id);
            n_out_len = len8[3:0];
            for (int k = 0; k < FRAME_BYTE_SLOTS; k++) begin
                if (8'(k) < len8 && k < MAX_DATA_BYTES) begin
                    n_out_byte[k] = (wr_en && wr_idx == 3'(k)) ? wr_data : r_store[k];
                end
            end
        end
    end

    // Line state registers; every line end starts a fresh line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_tc    <= '0;
            r_id    <= '0;
            r_ovf   <= 1'b0;
            r_ba    <= '0;
            r_pend  <= 1'b0;
            r_skip  <= 1'b0;
            r_bad   <= 1'b0;
        end else if (eol_acc) begin
            r_phase <= PH_START;
            r_tc    <= '0;
            r_id    <= '0;
            r_ovf   <= 1'b0;
            r_ba    <= '0;
            r_pend  <= 1'b0;
            r_skip  <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_tc    <= n_tc;
            r_id    <= n_id;
            r_ovf   <= n_ovf;
            r_ba    <= n_ba;
            r_pend  <= n_pend;
            r_skip  <= n_skip;
            r_bad   <= n_bad;
        end
    end

    // Data byte store.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_idx] <= wr_data;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eol_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (eol_acc) begin
            r_out_status <= n_out_status;
            r_out_id     <= n_out_id;
            r_out_len    <= n_out_len;
            r_out_byte   <= n_out_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_frame_id  = r_out_id;
    assign o_length    = r_out_len;
    assign o_byte0     = r_out_byte[0];
    assign o_byte1     = r_out_byte[1];
    assign o_byte2     = r_out_byte[2];
    assign o_byte3     = r_out_byte[3];
    assign o_byte4     = r_out_byte[4];
    assign o_byte5     = r_out_byte[5];
    assign o_byte6     = r_out_byte[6];
    assign o_byte7     = r_out_byte[7];

endmodule
